// ===== src/cmc_pkg.sv =====
// Shared types, constants and fixed-point helpers of the cascaded motor controller.
`default_nettype none
package cmc_pkg;
	localparam int DW = 32;
	localparam int FB = 16;
	localparam int GW = DW - 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int MODE_W = 3;

	localparam logic [MODE_W-1:0] MODE_CURRENT       = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CURRENT_RAMP  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_VELOCITY      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_VELOCITY_RAMP = 3'd3;
	localparam logic [MODE_W-1:0] MODE_POSITION      = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_INERTIA         = 3'd7;

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_RESET = 1'b1;

	typedef logic signed [DW-1:0] fx_t;
	typedef logic [GW-1:0] ufx_t;
	typedef logic signed [DW+1:0] fx_wide_t;

	typedef struct packed {
		logic action;
		fx_t  measured_position;
		fx_t  measured_velocity;
		fx_t  target_position;
		fx_t  velocity_goal;
		fx_t  current_goal;
	} cmc_req_t;

	typedef struct packed {
		fx_t  current_command;
		logic limited;
	} cmc_rsp_t;

	typedef struct packed {
		logic start;
		fx_t  a;
		ufx_t b;
	} cmc_mul_req_t;

	typedef struct packed {
		logic done;
		fx_t  p;
	} cmc_mul_rsp_t;

	function automatic fx_wide_t ext_fx(input fx_t v);
		return {{2{v[DW-1]}}, v};
	endfunction

	function automatic fx_t sat_fx(input fx_wide_t v);
		fx_wide_t hi;
		fx_wide_t lo;
		hi = {3'b000, {(DW-1){1'b1}}};
		lo = {3'b111, {(DW-1){1'b0}}};
		if (v > hi) begin
			return hi[DW-1:0];
		end
		if (v < lo) begin
			return lo[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	function automatic fx_t sat_add(input fx_t a, input fx_t b);
		return sat_fx(ext_fx(a) + ext_fx(b));
	endfunction

	function automatic fx_t sat_sub(input fx_t a, input fx_t b);
		return sat_fx(ext_fx(a) - ext_fx(b));
	endfunction

	function automatic fx_t clamp_sym(input fx_t v, input ufx_t lim);
		fx_t p;
		fx_t n;
		p = $signed({1'b0, lim});
		n = -p;
		if (v > p) begin
			return p;
		end
		if (v < n) begin
			return n;
		end
		return v;
	endfunction
endpackage
`default_nettype wire

// ===== src/cmc_mul.sv =====
// Three-stage signed-by-unsigned fixed-point multiplier with rounding and saturation.
`default_nettype none
module cmc_mul import cmc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cmc_mul_req_t mul_req,
	output cmc_mul_rsp_t mul_rsp
);
	localparam int PW = DW + GW;
	localparam int RW = PW + 1 - FB;
	localparam logic [PW:0] RND = (PW + 1)'(1) << (FB - 1);
	localparam logic [RW-1:0] POS_LIM = (RW'(1) << (DW - 1)) - RW'(1);
	localparam logic [RW-1:0] NEG_LIM = RW'(1) << (DW - 1);

	logic            v_s1, v_s2, v_s3;
	logic            neg_s1, neg_s2;
	logic [DW-1:0]   mag_s1;
	ufx_t            gain_s1;
	logic [PW-1:0]   prod_s2;
	fx_t             p_s3;
	logic [PW:0]     rnd;
	logic [RW-1:0]   rmag;
	logic [RW-1:0]   rlim;
	logic [DW-1:0]   rcut;

	always_comb begin
		rnd  = {1'b0, prod_s2} + RND;
		rmag = rnd[PW:FB];
		rlim = neg_s2 ? NEG_LIM : POS_LIM;
		rcut = (rmag > rlim) ? rlim[DW-1:0] : rmag[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= mul_req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= mul_req.a[DW-1];
		mag_s1  <= mul_req.a[DW-1] ? (~unsigned'(mul_req.a) + 1'b1) : unsigned'(mul_req.a);
		gain_s1 <= mul_req.b;
		neg_s2  <= neg_s1;
		prod_s2 <= PW'(mag_s1) * PW'(gain_s1);
		p_s3    <= neg_s2 ? $signed(-rcut) : $signed(rcut);
	end

	assign mul_rsp.done = v_s3;
	assign mul_rsp.p    = p_s3;
endmodule
`default_nettype wire

// ===== src/cascaded_motor_controller.sv =====
// Top level of the cascaded position / velocity PI motor controller.
// Each request is one control tick or one controller reset, answered by one current
// command in signed Q16.16. A reset, a current-mode tick or a tick in an undefined mode
// goes straight to the output; a current-ramp tick adds one ramp step, and velocity,
// velocity-ramp and position ticks run the PI loop. A tick that saturates at the current
// limit skips the integrator update. All products go one after another through a single
// three-stage 32x31 multiplier. req_ready is high only while no request is in work; a
// finished result waits in the output register, and while that register is full and
// unread the request holds in its last cycle.
`default_nettype none
module cascaded_motor_controller import cmc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  cmc_req_t              req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output cmc_rsp_t              rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	typedef enum logic [13:0] {
		S_IDLE    = 14'b00000000000001,
		S_FIRST   = 14'b00000000000010,
		S_STEP    = 14'b00000000000100,
		S_FF_MUL  = 14'b00000000001000,
		S_FF_WAIT = 14'b00000000010000,
		S_P_WAIT  = 14'b00000000100000,
		S_P_SUM   = 14'b00000001000000,
		S_VERR    = 14'b00000010000000,
		S_KV_MUL  = 14'b00000100000000,
		S_KV_WAIT = 14'b00001000000000,
		S_PI_SUM  = 14'b00010000000000,
		S_KI_MUL  = 14'b00100000000000,
		S_KI_WAIT = 14'b01000000000000,
		S_OUT     = 14'b10000000000000
	} state_t;

	state_t        state_q, state_d;
	logic [MODE_W-1:0] mode_q;
	ufx_t          cur_lim_q, vel_lim_q, kp_q, kv_q, ki_q, rstep_q, inertia_q;
	fx_t           integ_q, pos_sp_q, vel_sp_q, cur_sp_q;
	cmc_req_t      req_q;
	fx_t           tmp_q, vdes_q, verr_q, term_q, res_q;
	logic          lim_q;
	logic          rsp_valid_q;
	cmc_rsp_t      rsp_q;
	cmc_mul_req_t  mul_req;
	cmc_mul_rsp_t  mul_rsp;

	fx_t           cur_tgt, vel_tgt, step_c, ramp_base, ramp_new, pi_cmd, ilim_p, ilim_n;
	fx_wide_t      pi_sum;
	logic          slot_free;

	cmc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.mul_req (mul_req),
		.mul_rsp (mul_rsp)
	);

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		cur_tgt   = clamp_sym(req_q.current_goal, cur_lim_q);
		vel_tgt   = clamp_sym(req_q.velocity_goal, vel_lim_q);
		step_c    = clamp_sym(tmp_q, rstep_q);
		ramp_base = (mode_q == MODE_CURRENT_RAMP) ? cur_sp_q : vel_sp_q;
		ramp_new  = sat_add(ramp_base, step_c);
		pi_sum    = ext_fx(cur_sp_q) + ext_fx(term_q) + ext_fx(integ_q);
		pi_cmd    = sat_fx(pi_sum);
		ilim_p    = $signed({1'b0, cur_lim_q});
		ilim_n    = -ilim_p;
	end

	always_comb begin
		mul_req.start = (state_q == S_FF_MUL) || (state_q == S_KV_MUL) ||
			(state_q == S_KI_MUL) || (state_q == S_STEP && mode_q == MODE_POSITION);
		mul_req.a = verr_q;
		mul_req.b = kv_q;
		case (state_q)
			S_STEP: begin
				mul_req.a = tmp_q;
				mul_req.b = kp_q;
			end
			S_FF_MUL: begin
				mul_req.a = tmp_q;
				mul_req.b = inertia_q;
			end
			S_KI_MUL: begin
				mul_req.b = ki_q;
			end
			default: begin
				mul_req.b = kv_q;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_FIRST;
			end
			S_FIRST: begin
				if (req_q.action == ACT_RESET) begin
					state_d = S_OUT;
				end else begin
					case (mode_q)
						MODE_CURRENT_RAMP, MODE_VELOCITY_RAMP, MODE_POSITION: state_d = S_STEP;
						MODE_VELOCITY: state_d = S_VERR;
						default: state_d = S_OUT;
					endcase
				end
			end
			S_STEP: begin
				case (mode_q)
					MODE_CURRENT_RAMP: state_d = S_OUT;
					MODE_VELOCITY_RAMP: state_d = S_FF_MUL;
					default: state_d = S_P_WAIT;
				endcase
			end
			S_FF_MUL: state_d = S_FF_WAIT;
			S_FF_WAIT: begin
				if (mul_rsp.done) state_d = S_VERR;
			end
			S_P_WAIT: begin
				if (mul_rsp.done) state_d = S_P_SUM;
			end
			S_P_SUM: state_d = S_VERR;
			S_VERR: state_d = S_KV_MUL;
			S_KV_MUL: state_d = S_KV_WAIT;
			S_KV_WAIT: begin
				if (mul_rsp.done) state_d = S_PI_SUM;
			end
			S_PI_SUM: begin
				if (pi_cmd > ilim_p || pi_cmd < ilim_n) state_d = S_OUT;
				else state_d = S_KI_MUL;
			end
			S_KI_MUL: state_d = S_KI_WAIT;
			S_KI_WAIT: begin
				if (mul_rsp.done) state_d = S_OUT;
			end
			S_OUT: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			mode_q      <= '0;
			cur_lim_q   <= '0;
			vel_lim_q   <= '0;
			kp_q        <= '0;
			kv_q        <= '0;
			ki_q        <= '0;
			rstep_q     <= '0;
			inertia_q   <= '0;
			integ_q     <= '0;
			pos_sp_q    <= '0;
			vel_sp_q    <= '0;
			cur_sp_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_CONTROL_MODE:   mode_q    <= cfg_data[MODE_W-1:0];
					REG_CURRENT_LIMIT:  cur_lim_q <= cfg_data[GW-1:0];
					REG_VELOCITY_LIMIT: vel_lim_q <= cfg_data[GW-1:0];
					REG_POSITION_GAIN:  kp_q      <= cfg_data[GW-1:0];
					REG_VELOCITY_GAIN:  kv_q      <= cfg_data[GW-1:0];
					REG_INTEGRAL_GAIN:  ki_q      <= cfg_data[GW-1:0];
					REG_RAMP_STEP:      rstep_q   <= cfg_data[GW-1:0];
					REG_INERTIA:        inertia_q <= cfg_data[GW-1:0];
					default:            mode_q    <= mode_q;
				endcase
			end
			case (state_q)
				S_FIRST: begin
					if (req_q.action == ACT_RESET) begin
						integ_q  <= '0;
						pos_sp_q <= req_q.measured_position;
						vel_sp_q <= '0;
						cur_sp_q <= '0;
					end else begin
						case (mode_q)
							MODE_CURRENT:  cur_sp_q <= cur_tgt;
							MODE_VELOCITY: vel_sp_q <= vel_tgt;
							MODE_POSITION: pos_sp_q <= req_q.target_position;
							default:       cur_sp_q <= cur_sp_q;
						endcase
					end
				end
				S_STEP: begin
					if (mode_q == MODE_CURRENT_RAMP) cur_sp_q <= ramp_new;
					if (mode_q == MODE_VELOCITY_RAMP) vel_sp_q <= ramp_new;
				end
				S_FF_WAIT: begin
					if (mul_rsp.done) cur_sp_q <= mul_rsp.p;
				end
				S_KI_WAIT: begin
					if (mul_rsp.done) integ_q <= sat_add(integ_q, mul_rsp.p);
				end
				default: begin
					integ_q <= integ_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) req_q <= req;
		if (state_q == S_OUT && slot_free) begin
			rsp_q.current_command <= res_q;
			rsp_q.limited         <= lim_q;
		end
		case (state_q)
			S_FIRST: begin
				res_q <= '0;
				lim_q <= 1'b0;
				if (req_q.action == ACT_TICK) begin
					case (mode_q)
						MODE_CURRENT:       res_q  <= cur_tgt;
						MODE_CURRENT_RAMP:  tmp_q  <= sat_sub(cur_tgt, cur_sp_q);
						MODE_VELOCITY:      vdes_q <= vel_tgt;
						MODE_VELOCITY_RAMP: tmp_q  <= sat_sub(vel_tgt, vel_sp_q);
						MODE_POSITION: begin
							tmp_q <= sat_sub(req_q.target_position, req_q.measured_position);
						end
						default: res_q <= '0;
					endcase
				end
			end
			S_STEP: begin
				res_q  <= ramp_new;
				vdes_q <= ramp_new;
				tmp_q  <= step_c;
			end
			S_P_WAIT: begin
				if (mul_rsp.done) term_q <= mul_rsp.p;
			end
			S_P_SUM: begin
				vdes_q <= clamp_sym(sat_add(vel_sp_q, term_q), vel_lim_q);
			end
			S_VERR: begin
				verr_q <= sat_sub(vdes_q, req_q.measured_velocity);
			end
			S_KV_WAIT: begin
				if (mul_rsp.done) term_q <= mul_rsp.p;
			end
			S_PI_SUM: begin
				if (pi_cmd > ilim_p) begin
					res_q <= ilim_p;
					lim_q <= 1'b1;
				end else if (pi_cmd < ilim_n) begin
					res_q <= ilim_n;
					lim_q <= 1'b1;
				end else begin
					res_q <= pi_cmd;
					lim_q <= 1'b0;
				end
			end
			default: begin
				lim_q <= lim_q;
			end
		endcase
	end

	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == S_FF_WAIT || state_q == S_P_WAIT ||
			state_q == S_KV_WAIT || state_q == S_KI_WAIT))
		else $error("multiplier result outside a wait step");

	a_integ_hold_on_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PI_SUM && (pi_cmd > ilim_p || pi_cmd < ilim_n)) |=>
			($stable(integ_q) && state_q == S_OUT))
		else $error("integrator moved while the PI output was clamped");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && slot_free) |=> (rsp_valid && req_ready))
		else $error("finished request not handed to the output register");

	a_start_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |=> !mul_rsp.done)
		else $error("multiplier launched with a product in flight");
endmodule
`default_nettype wire

// ===== tb/cmc_checker.sv =====
// Checker that predicts the motor controller's current commands and compares each result.
module cmc_checker import cmc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  cmc_req_t              req,
	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  cmc_rsp_t              rsp,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    outstanding,
	output int                    commands_checked,
	output int                    limited_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint Q_MAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
	localparam longint Q_MIN = -Q_MAX - 64'sd1;

	logic [MODE_W-1:0] mode_q;
	ufx_t current_limit_q;
	ufx_t velocity_limit_q;
	ufx_t position_gain_q;
	ufx_t velocity_gain_q;
	ufx_t integral_gain_q;
	ufx_t ramp_step_q;
	ufx_t inertia_q;

	longint integrator_q;
	longint position_sp_q;
	longint velocity_sp_q;
	longint current_sp_q;

	cmc_rsp_t command_q[$];
	int fails;
	int checked;
	int hits;

	function automatic longint sat_q(input longint v);
		if (v > Q_MAX) begin
			return Q_MAX;
		end
		if (v < Q_MIN) begin
			return Q_MIN;
		end
		return v;
	endfunction

	function automatic longint clamp_q(input longint v, input longint lim);
		if (v > lim) begin
			return lim;
		end
		if (v < -lim) begin
			return -lim;
		end
		return v;
	endfunction

	function automatic longint mul_q(input longint a, input longint b);
		logic [63:0] ua;
		logic [63:0] ub;
		logic [63:0] mag;
		logic [63:0] cap;
		logic neg;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? 64'(-a) : 64'(a);
		ub = (b < 0) ? 64'(-b) : 64'(b);
		mag = (ua * ub + (64'd1 << (FB - 1))) >> FB;
		cap = neg ? 64'(Q_MAX) + 64'd1 : 64'(Q_MAX);
		if (mag > cap) begin
			mag = cap;
		end
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic cmc_rsp_t predict_command(input cmc_req_t r);
		longint mpos;
		longint mvel;
		longint tpos;
		longint tvel;
		longint tcur;
		longint ilim;
		longint vlim;
		longint rstep;
		longint cmd;
		longint vdes;
		longint delta;
		longint verr;
		cmc_rsp_t o;
		mpos = longint'(r.measured_position);
		mvel = longint'(r.measured_velocity);
		tpos = longint'(r.target_position);
		tvel = longint'(r.velocity_goal);
		tcur = longint'(r.current_goal);
		ilim = longint'(current_limit_q);
		vlim = longint'(velocity_limit_q);
		rstep = longint'(ramp_step_q);
		cmd = 0;
		vdes = 0;
		o.limited = 1'b0;
		if (r.action == ACT_RESET) begin
			integrator_q = 0;
			position_sp_q = mpos;
			velocity_sp_q = 0;
			current_sp_q = 0;
		end else if (mode_q == MODE_CURRENT || mode_q == MODE_CURRENT_RAMP) begin
			if (mode_q == MODE_CURRENT) begin
				current_sp_q = clamp_q(tcur, ilim);
			end else begin
				delta = clamp_q(sat_q(clamp_q(tcur, ilim) - current_sp_q), rstep);
				current_sp_q = sat_q(current_sp_q + delta);
			end
			cmd = current_sp_q;
		end else if (mode_q <= MODE_POSITION) begin
			if (mode_q == MODE_VELOCITY) begin
				velocity_sp_q = clamp_q(tvel, vlim);
				vdes = velocity_sp_q;
			end else if (mode_q == MODE_VELOCITY_RAMP) begin
				delta = clamp_q(sat_q(clamp_q(tvel, vlim) - velocity_sp_q), rstep);
				velocity_sp_q = sat_q(velocity_sp_q + delta);
				current_sp_q = mul_q(delta, longint'(inertia_q));
				vdes = velocity_sp_q;
			end else begin
				position_sp_q = tpos;
				vdes = sat_q(velocity_sp_q +
					mul_q(longint'(position_gain_q), sat_q(position_sp_q - mpos)));
				vdes = clamp_q(vdes, vlim);
			end
			verr = sat_q(vdes - mvel);
			cmd = sat_q(current_sp_q + mul_q(longint'(velocity_gain_q), verr) + integrator_q);
			if (cmd < -ilim) begin
				cmd = -ilim;
				o.limited = 1'b1;
			end else if (cmd > ilim) begin
				cmd = ilim;
				o.limited = 1'b1;
			end else begin
				integrator_q = sat_q(integrator_q + mul_q(longint'(integral_gain_q), verr));
			end
		end
		o.current_command = cmd[DW-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cmc_rsp_t want;
		if (!arst_n) begin
			mode_q = MODE_CURRENT;
			current_limit_q = '0;
			velocity_limit_q = '0;
			position_gain_q = '0;
			velocity_gain_q = '0;
			integral_gain_q = '0;
			ramp_step_q = '0;
			inertia_q = '0;
			integrator_q = 0;
			position_sp_q = 0;
			velocity_sp_q = 0;
			current_sp_q = 0;
			command_q.delete();
			fails = 0;
			checked = 0;
			hits = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CONTROL_MODE: mode_q = cfg_data[MODE_W-1:0];
					REG_CURRENT_LIMIT: current_limit_q = cfg_data[GW-1:0];
					REG_VELOCITY_LIMIT: velocity_limit_q = cfg_data[GW-1:0];
					REG_POSITION_GAIN: position_gain_q = cfg_data[GW-1:0];
					REG_VELOCITY_GAIN: velocity_gain_q = cfg_data[GW-1:0];
					REG_INTEGRAL_GAIN: integral_gain_q = cfg_data[GW-1:0];
					REG_RAMP_STEP: ramp_step_q = cfg_data[GW-1:0];
					default: inertia_q = cfg_data[GW-1:0];
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (rsp.limited === 1'b1) begin
					hits++;
				end
				if (command_q.size() == 0) begin
					fails++;
					if (fails <= 10) begin
						$display("[%0t] unexpected result: current_command %0d limited %0b",
							$realtime, rsp.current_command, rsp.limited);
					end
				end else begin
					want = command_q.pop_front();
					checked++;
					if (rsp.current_command !== want.current_command ||
						rsp.limited !== want.limited) begin
						fails++;
						if (fails <= 10) begin
							$display("[%0t] result %0d: current_command exp %0d got %0d, %s",
								$realtime, checked, want.current_command,
								rsp.current_command,
								$sformatf("limited exp %0b got %0b", want.limited,
									rsp.limited));
						end
					end
				end
			end
			if (req_valid && req_ready) begin
				command_q.push_back(predict_command(req));
			end
		end
		fail_count <= fails;
		outstanding <= command_q.size();
		commands_checked <= checked;
		limited_seen <= hits;
	end
endmodule

// ===== tb/testbench.sv =====
// Testbench top that drives requests and register writes into the motor controller.
module testbench import cmc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 800000;
	localparam int RANDOM_ITEMS = 1600;
	localparam int DRAIN_CYCLES = 40;
	localparam fx_t FX_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam fx_t FX_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam fx_t FX_ONE = 1 << FB;
	localparam logic [MODE_W-1:0] MODE_TOP = '1;
	localparam logic [MODE_W-1:0] MODE_FIRST_UNDEF = MODE_POSITION + 3'd1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	cmc_req_t              req = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	cmc_rsp_t              rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int outstanding;
	int commands_checked;
	int limited_seen;

	int cycles = 0;
	int burst_left = 0;
	int sent_items = 0;
	int reset_items = 0;
	int cfg_writes = 0;
	int settings = 0;
	int random_sent = 0;
	int stall_style = 0;
	int style_left = 0;

	cascaded_motor_controller u_top (
		.clk, .arst_n, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	cmc_checker u_checker (
		.clk, .arst_n, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.fail_count, .outstanding, .commands_checked, .limited_seen
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (style_left == 0) begin
			stall_style <= $urandom_range(0, 2);
			style_left <= $urandom_range(50, 300);
		end else begin
			style_left <= style_left - 1;
		end
		case (stall_style)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= 1'($urandom_range(0, 1));
			default: rsp_ready <= ($urandom_range(0, 15) < 3);
		endcase
	end

	function automatic fx_t small_value(input int span);
		return fx_t'($urandom) >>> (DW - 1 - span);
	endfunction

	function automatic fx_t pick_value();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 4) begin
			return FX_MAX;
		end
		if (sel < 8) begin
			return FX_MIN;
		end
		if (sel < 10) begin
			return '0;
		end
		if (sel < 35) begin
			return fx_t'($urandom);
		end
		return small_value(20);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input int span);
		logic [CFG_DATA_W-1:0] v;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			return '0;
		end
		if (sel < 16) begin
			return {1'b0, {GW{1'b1}}};
		end
		if (sel < 24) begin
			return $urandom;
		end
		v = $urandom_range(0, 1 << span);
		v[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
		return v;
	endfunction

	function automatic cmc_req_t make_item(input logic act, input fx_t mp, input fx_t mv,
		input fx_t tp, input fx_t tv, input fx_t tc);
		cmc_req_t r;
		r.action = act;
		r.measured_position = mp;
		r.measured_velocity = mv;
		r.target_position = tp;
		r.velocity_goal = tv;
		r.current_goal = tc;
		return r;
	endfunction

	function automatic cmc_req_t random_item(input fx_t anchor, input int span);
		cmc_req_t r;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 12) begin
			r = make_item(1'($urandom_range(0, 1)), pick_value(), pick_value(), pick_value(),
				pick_value(), pick_value());
		end else begin
			r.action = (sel < 17) ? ACT_RESET : ACT_TICK;
			r.target_position = anchor + small_value(span);
			r.measured_position = anchor + small_value(span);
			r.velocity_goal = small_value(span);
			r.measured_velocity = r.velocity_goal + small_value(span - 2);
			r.current_goal = small_value(span);
		end
		return r;
	endfunction

	task automatic send_request(input cmc_req_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		sent_items++;
		if (item.action == ACT_RESET) begin
			reset_items++;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		cfg_writes++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		settings++;
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		logic [CFG_DATA_W-1:0] d;
		d = $urandom;
		d[MODE_W-1:0] = m;
		write_reg(REG_CONTROL_MODE, d);
	endtask

	initial begin
		fx_t anchor;
		int span;
		int n;
		bit all_regs;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_item(ACT_TICK, '0, '0, '0, '0, FX_MAX));
		drain();
		write_reg(REG_CURRENT_LIMIT, 32'hFFFF_FFFF);
		send_request(make_item(ACT_TICK, '0, '0, '0, '0, FX_MAX));
		send_request(make_item(ACT_TICK, FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MIN));
		send_request(make_item(ACT_TICK, '0, '0, '0, '0, -FX_ONE * 3));

		drain();
		write_mode(MODE_CURRENT_RAMP);
		write_reg(REG_RAMP_STEP, 32'h0001_0000);
		write_reg(REG_CURRENT_LIMIT, 32'h0005_0000);
		repeat (3) send_request(make_item(ACT_TICK, '0, '0, '0, '0, FX_ONE * 100));
		send_request(make_item(ACT_TICK, '0, '0, '0, '0, FX_MIN));

		drain();
		write_mode(MODE_VELOCITY);
		write_reg(REG_VELOCITY_LIMIT, 32'h7FFF_FFFF);
		write_reg(REG_VELOCITY_GAIN, 32'h0001_0000);
		write_reg(REG_INTEGRAL_GAIN, 32'h0000_2000);
		write_reg(REG_CURRENT_LIMIT, 32'h0000_0000);
		send_request(make_item(ACT_RESET, FX_ONE * 12, '0, '0, '0, '0));
		send_request(make_item(ACT_TICK, '0, FX_ONE / 2, '0, FX_ONE / 2, '0));
		send_request(make_item(ACT_TICK, '0, FX_MIN, '0, FX_MAX, '0));

		drain();
		write_reg(REG_CURRENT_LIMIT, 32'h7FFF_FFFF);
		write_reg(REG_INTEGRAL_GAIN, 32'h7FFF_FFFF);
		send_request(make_item(ACT_TICK, '0, FX_MIN, '0, FX_MAX, '0));
		send_request(make_item(ACT_TICK, '0, FX_MAX, '0, FX_MIN, '0));

		drain();
		write_mode(MODE_VELOCITY_RAMP);
		write_reg(REG_INERTIA, 32'h7FFF_FFFF);
		write_reg(REG_RAMP_STEP, 32'h0001_0000);
		write_reg(REG_INTEGRAL_GAIN, 32'h0000_2000);
		write_reg(REG_CURRENT_LIMIT, 32'h0100_0000);
		send_request(make_item(ACT_RESET, -FX_ONE * 7, '0, '0, '0, '0));
		repeat (2) send_request(make_item(ACT_TICK, '0, '0, '0, FX_ONE * 50, '0));
		send_request(make_item(ACT_TICK, '0, FX_ONE, '0, FX_MIN, '0));

		drain();
		write_mode(MODE_POSITION);
		write_reg(REG_POSITION_GAIN, 32'h7FFF_FFFF);
		write_reg(REG_VELOCITY_LIMIT, 32'h000A_0000);
		send_request(make_item(ACT_TICK, FX_MIN, '0, FX_MAX, '0, '0));
		send_request(make_item(ACT_TICK, FX_MAX, '0, FX_MIN, '0, '0));
		send_request(make_item(ACT_TICK, FX_ONE, -FX_ONE / 2, FX_ONE * 3, '0, '0));

		drain();
		write_mode(MODE_FIRST_UNDEF);
		send_request(make_item(ACT_TICK, FX_ONE, FX_ONE, FX_MAX, FX_MIN, FX_MAX));
		drain();
		write_mode(MODE_TOP);
		send_request(make_item(ACT_TICK, '0, '0, FX_ONE, FX_ONE, FX_ONE));
		send_request(make_item(ACT_RESET, FX_MAX, '0, '0, '0, '0));

		all_regs = 1'b1;
		while (random_sent < RANDOM_ITEMS) begin
			drain();
			if ($urandom_range(0, 9) == 0) begin
				write_mode(MODE_W'($urandom_range(MODE_FIRST_UNDEF, MODE_TOP)));
			end else begin
				write_mode(MODE_W'($urandom_range(MODE_CURRENT, MODE_POSITION)));
			end
			if (all_regs || $urandom_range(0, 1)) write_reg(REG_CURRENT_LIMIT, pick_reg_value(22));
			if (all_regs || $urandom_range(0, 1)) write_reg(REG_VELOCITY_LIMIT, pick_reg_value(22));
			if (all_regs || $urandom_range(0, 1)) write_reg(REG_POSITION_GAIN, pick_reg_value(18));
			if (all_regs || $urandom_range(0, 1)) write_reg(REG_VELOCITY_GAIN, pick_reg_value(18));
			if (all_regs || $urandom_range(0, 1)) write_reg(REG_INTEGRAL_GAIN, pick_reg_value(14));
			if (all_regs || $urandom_range(0, 1)) write_reg(REG_RAMP_STEP, pick_reg_value(18));
			if (all_regs || $urandom_range(0, 1)) write_reg(REG_INERTIA, pick_reg_value(18));
			all_regs = 1'b0;
			anchor = pick_value();
			span = $urandom_range(12, 24);
			n = $urandom_range(10, 90);
			repeat (n) begin
				send_request(random_item(anchor, span));
				anchor = anchor + small_value(12);
				random_sent++;
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests (%0d controller resets) across %0d register settings,",
			sent_items, reset_items, settings);
		$display("%0d register writes; checked %0d current commands, %0d clamped at the limit",
			cfg_writes, commands_checked, limited_seen);
		if (fail_count == 0 && outstanding == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
